FILE: design/asls_pkg.sv
package asls_pkg;

	localparam int unsigned MAX_STATIONS_DEF = 64;
	localparam int unsigned COST_W = 24;
	localparam int unsigned TIME_W = 16;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_B = 2'd1;

	typedef logic [COST_W-1:0] cost_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_a;
		logic [TIME_W-1:0] time_b;
		logic [TIME_W-1:0] move_to_a_cost;
		logic [TIME_W-1:0] move_to_b_cost;
		logic              last_station;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] station_index;
		logic             line_used;
		cost_t            total_cost;
		logic             overflow;
		logic             last_of_path;
	} result_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_FIN,
		ST_TRACE
	} back_state_t;

	function automatic cost_t sat_add(input cost_t x, input cost_t y);
		logic [COST_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[COST_W] ? '1 : s[COST_W-1:0];
	endfunction

endpackage

FILE: design/asls_front.sv
module asls_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  asls_pkg::item_t       item,
	output asls_pkg::q_head_t     head,
	input  logic                  pop
);

	asls_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            push;

	assign busy = (fill_q == 2'd2);
	assign push = start && !busy;
	assign head.valid = (fill_q != 2'd0);
	assign head.item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: design/asls_back.sv
module asls_back #(
	parameter int unsigned MAX_STATIONS = asls_pkg::MAX_STATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [asls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asls_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  asls_pkg::q_head_t                 head,
	output logic                              pop,
	output logic                              result_strobe,
	output asls_pkg::result_t                 result
);

	localparam int unsigned AW = $clog2(MAX_STATIONS);
	localparam int unsigned CW = $clog2(MAX_STATIONS + 1);

	asls_pkg::back_state_t state_q, state_nxt;

	logic [asls_pkg::CFG_DATA_W-1:0] exit_a_q, exit_b_q;
	asls_pkg::cost_t best_a_q, best_b_q;
	logic [CW-1:0]   count_q;
	logic            overflow_q;

	// choice memory: bit 0 = predecessor of A, bit 1 = predecessor of B
	logic [1:0]      choice_mem [MAX_STATIONS];
	logic [1:0]      rd_data_q;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic [1:0]      wr_data;

	// first half of a station step
	asls_pkg::cost_t stay_a_s1, stay_b_s1, mid_a_s1, mid_b_s1;
	logic [asls_pkg::TIME_W-1:0] ta_s1, tb_s1;
	logic            last_s1;

	asls_pkg::cost_t sw_a, sw_b, fa, fb;
	logic            pick_sw_a, pick_sw_b;
	logic            full, first;
	logic [CW-1:0]   cnt_m1;

	logic [AW-1:0]   j_q;
	logic            line_q;
	asls_pkg::cost_t total_q;

	assign sw_a = asls_pkg::sat_add(mid_a_s1, asls_pkg::cost_t'(ta_s1));
	assign sw_b = asls_pkg::sat_add(mid_b_s1, asls_pkg::cost_t'(tb_s1));
	assign pick_sw_a = !(stay_a_s1 <= sw_a);
	assign pick_sw_b = !(stay_b_s1 <= sw_b);
	assign full = (count_q >= CW'(MAX_STATIONS));
	assign first = (count_q == '0);
	assign cnt_m1 = count_q - CW'(1);
	assign fa = asls_pkg::sat_add(best_a_q, asls_pkg::cost_t'(exit_a_q));
	assign fb = asls_pkg::sat_add(best_b_q, asls_pkg::cost_t'(exit_b_q));
	assign wr_data = first ? 2'b10 : {!pick_sw_b, pick_sw_a};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			asls_pkg::ST_IDLE: if (head.valid) begin
				state_nxt = asls_pkg::ST_STEP;
			end
			asls_pkg::ST_STEP: state_nxt = last_s1 ? asls_pkg::ST_FIN : asls_pkg::ST_IDLE;
			asls_pkg::ST_FIN: state_nxt = asls_pkg::ST_TRACE;
			asls_pkg::ST_TRACE: if (j_q == '0) begin
				state_nxt = asls_pkg::ST_IDLE;
			end
			default: state_nxt = asls_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		mem_we = 1'b0;
		rd_addr = j_q - AW'(1);
		unique case (state_q)
			asls_pkg::ST_IDLE: pop = head.valid;
			asls_pkg::ST_STEP: mem_we = !full;
			asls_pkg::ST_FIN: rd_addr = cnt_m1[AW-1:0];
			asls_pkg::ST_TRACE: rd_addr = j_q - AW'(1);
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			choice_mem[count_q[AW-1:0]] <= wr_data;
		end
		rd_data_q <= choice_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == asls_pkg::ST_IDLE) begin
			stay_a_s1 <= asls_pkg::sat_add(best_a_q, asls_pkg::cost_t'(head.item.time_a));
			stay_b_s1 <= asls_pkg::sat_add(best_b_q, asls_pkg::cost_t'(head.item.time_b));
			mid_a_s1 <= asls_pkg::sat_add(best_b_q,
				asls_pkg::cost_t'(head.item.move_to_a_cost));
			mid_b_s1 <= asls_pkg::sat_add(best_a_q,
				asls_pkg::cost_t'(head.item.move_to_b_cost));
			ta_s1 <= head.item.time_a;
			tb_s1 <= head.item.time_b;
			last_s1 <= head.item.last_station;
		end
		if (state_q == asls_pkg::ST_FIN) begin
			line_q <= !(fa <= fb);
			total_q <= (fa <= fb) ? fa : fb;
			j_q <= cnt_m1[AW-1:0];
		end else if (state_q == asls_pkg::ST_TRACE) begin
			line_q <= rd_data_q[line_q];
			j_q <= j_q - AW'(1);
		end
		result.station_index <= asls_pkg::IDX_W'(j_q);
		result.line_used <= line_q;
		result.total_cost <= total_q;
		result.overflow <= overflow_q;
		result.last_of_path <= (j_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asls_pkg::ST_IDLE;
			exit_a_q <= '0;
			exit_b_q <= '0;
			best_a_q <= '0;
			best_b_q <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			state_q <= state_nxt;
			result_strobe <= (state_q == asls_pkg::ST_TRACE);
			if (cfg_valid) begin
				if (cfg_index == asls_pkg::CFG_EXIT_A) begin
					exit_a_q <= cfg_data;
				end else if (cfg_index == asls_pkg::CFG_EXIT_B) begin
					exit_b_q <= cfg_data;
				end
			end
			if (state_q == asls_pkg::ST_STEP) begin
				priority if (full) begin
					overflow_q <= 1'b1;
				end else if (first) begin
					best_a_q <= asls_pkg::cost_t'(ta_s1);
					best_b_q <= asls_pkg::cost_t'(tb_s1);
					count_q <= CW'(1);
				end else begin
					best_a_q <= pick_sw_a ? sw_a : stay_a_s1;
					best_b_q <= pick_sw_b ? sw_b : stay_b_s1;
					count_q <= count_q + CW'(1);
				end
			end
			// problem closes after the station zero entry
			if (state_q == asls_pkg::ST_TRACE && j_q == '0) begin
				best_a_q <= '0;
				best_b_q <= '0;
				count_q <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/two_line_assembly_schedule.sv
// Two-line assembly scheduler. The back end takes each station through a
// saturating add stage, then compare/update; a 2-entry queue in front
// accepts items while the back end works. On the last station the exit
// choice is made in FIN, then one result per cycle follows for n stations,
// each strobe registered out of TRACE. Results cannot be stalled.
// Async active-low reset clears costs, counts, flags and exit registers.
module two_line_assembly_schedule #(
	parameter int unsigned MAX_STATIONS = asls_pkg::MAX_STATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  asls_pkg::item_t                   item,
	output logic                              result_strobe,
	output asls_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [asls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asls_pkg::CFG_DATA_W-1:0]   cfg_data
);

	asls_pkg::q_head_t head;
	logic              pop;

	assign cfg_ready = 1'b1;

	asls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	asls_back #(
		.MAX_STATIONS (MAX_STATIONS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.head          (head),
		.pop           (pop),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

FILE: bench/two_line_assembly_schedule_tb.sv
`timescale 1ns / 100ps

module two_line_assembly_schedule_tb;

	localparam int MAX_HELD = int'(asls_pkg::MAX_STATIONS_DEF);
	localparam int STATION_TARGET = 500;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int unsigned COST_CAP = 24'hFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	asls_pkg::item_t station = '0;
	logic result_strobe;
	asls_pkg::result_t entry;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [asls_pkg::CFG_IDX_W-1:0] cfg_index = asls_pkg::CFG_EXIT_A;
	logic [asls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// scheduler state as the testbench tracks it
	logic [15:0] exit_a = '0;
	logic [15:0] exit_b = '0;
	asls_pkg::cost_t run_a = '0;
	asls_pkg::cost_t run_b = '0;
	int held = 0;
	logic dropped = 1'b0;
	logic [1:0] came_from [MAX_HELD];

	asls_pkg::result_t path_due[$];
	int mismatches = 0;
	int stations_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;

	two_line_assembly_schedule dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(station),
		.result_strobe(result_strobe),
		.result(entry),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[two_line_assembly_schedule] ERROR");
			$finish;
		end
	end

	function automatic asls_pkg::cost_t cost_sum(input asls_pkg::cost_t x,
			input asls_pkg::cost_t y);
		int unsigned s;
		s = x + y;
		return (s > COST_CAP) ? asls_pkg::cost_t'(COST_CAP) : asls_pkg::cost_t'(s);
	endfunction

	// One station of the DP; on the last station, queue the traced path.
	task automatic schedule_station(input asls_pkg::item_t it);
		asls_pkg::cost_t stay_a, hop_a, stay_b, hop_b, fin_a, fin_b, total;
		logic [1:0] pick;
		logic on_b;
		asls_pkg::result_t r;
		if (held >= MAX_HELD) begin
			dropped = 1'b1;
		end else if (held == 0) begin
			run_a = asls_pkg::cost_t'(it.time_a);
			run_b = asls_pkg::cost_t'(it.time_b);
			came_from[0] = 2'b10;
			held = 1;
		end else begin
			stay_a = cost_sum(run_a, asls_pkg::cost_t'(it.time_a));
			hop_a = cost_sum(cost_sum(run_b, asls_pkg::cost_t'(it.move_to_a_cost)),
				asls_pkg::cost_t'(it.time_a));
			stay_b = cost_sum(run_b, asls_pkg::cost_t'(it.time_b));
			hop_b = cost_sum(cost_sum(run_a, asls_pkg::cost_t'(it.move_to_b_cost)),
				asls_pkg::cost_t'(it.time_b));
			// bit 0: predecessor of A, bit 1: predecessor of B; stay wins ties
			pick[0] = stay_a > hop_a;
			pick[1] = stay_b <= hop_b;
			run_a = pick[0] ? hop_a : stay_a;
			run_b = pick[1] ? stay_b : hop_b;
			came_from[held] = pick;
			held++;
		end
		if (it.last_station) begin
			if (held > 0) begin
				fin_a = cost_sum(run_a, asls_pkg::cost_t'(exit_a));
				fin_b = cost_sum(run_b, asls_pkg::cost_t'(exit_b));
				on_b = fin_a > fin_b;
				total = on_b ? fin_b : fin_a;
				for (int j = held - 1; j >= 0; j--) begin
					r.station_index = j[asls_pkg::IDX_W-1:0];
					r.line_used = on_b;
					r.total_cost = total;
					r.overflow = dropped;
					r.last_of_path = (j == 0);
					path_due.insert(path_due.size(), r);
					if (j > 0)
						on_b = came_from[j][on_b];
				end
			end
			run_a = '0;
			run_b = '0;
			held = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		asls_pkg::result_t want;
		if (arst_n && result_strobe) begin
			if (path_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected path entry: idx=%0d line=%0d cost=%0d ovf=%0d end=%0d",
						entry.station_index, entry.line_used, entry.total_cost,
						entry.overflow, entry.last_of_path);
				mismatches++;
			end else begin
				want = path_due.pop_front();
				if (entry.station_index !== want.station_index ||
						entry.line_used !== want.line_used ||
						entry.total_cost !== want.total_cost ||
						entry.overflow !== want.overflow ||
						entry.last_of_path !== want.last_of_path) begin
					if (mismatches < 10)
						$display({"path entry mismatch: want idx=%0d line=%0d cost=%0d ovf=%0d ",
							"end=%0d, got idx=%0d line=%0d cost=%0d ovf=%0d end=%0d"},
							want.station_index, want.line_used, want.total_cost,
							want.overflow, want.last_of_path,
							entry.station_index, entry.line_used, entry.total_cost,
							entry.overflow, entry.last_of_path);
					mismatches++;
				end
			end
		end
	end

	function automatic asls_pkg::item_t make_station(input logic [15:0] ta,
			input logic [15:0] tb, input logic [15:0] ma, input logic [15:0] mb,
			input logic last);
		asls_pkg::item_t it;
		it.time_a = ta;
		it.time_b = tb;
		it.move_to_a_cost = ma;
		it.move_to_b_cost = mb;
		it.last_station = last;
		return it;
	endfunction

	function automatic logic [15:0] pick_time();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return $urandom_range(1, 8);
		if (r < 19)
			return $urandom_range(9, 40);
		return $urandom_range(41, 66);
	endfunction

	// Leaves start high after the transfer unless a gap follows.
	task automatic send_station(input asls_pkg::item_t it);
		int gap;
		start <= 1'b1;
		station <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		schedule_station(it);
		stations_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic drain_block();
		start <= 1'b0;
		while (path_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_exit_costs(input logic [15:0] a, input logic [15:0] b);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= asls_pkg::CFG_EXIT_A;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		exit_a = a;
		cfg_index <= asls_pkg::CFG_EXIT_B;
		cfg_data <= b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		exit_b = b;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_problem(input int len);
		for (int s = 0; s < len; s++)
			send_station(make_station(pick_time(), pick_time(), pick_time(), pick_time(),
				s == len - 1));
	endtask

	task automatic send_crossing_pair();
		send_station(make_station(16'd10, 16'd20, 16'd1, 16'd1, 1'b0));
		send_station(make_station(16'd20, 16'd10, 16'd5, 16'd5, 1'b1));
	endtask

	// switch costs must be ignored on the first station
	task automatic test_single_station();
		set_exit_costs(16'h0000, 16'h0000);
		send_station(make_station(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_station(make_station(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
		send_station(make_station(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
	endtask

	task automatic test_ties_and_switches();
		// every compare ties: stay on line, exit tie to A
		send_station(make_station(16'd5, 16'd5, 16'd9, 16'd9, 1'b0));
		send_station(make_station(16'd3, 16'd3, 16'd0, 16'd0, 1'b1));
		// cheap switch into B on the second station
		send_station(make_station(16'd1, 16'd100, 16'd7, 16'd7, 1'b0));
		send_station(make_station(16'd100, 16'd1, 16'd0, 16'd0, 1'b1));
		send_station(make_station(16'd100, 16'd1, 16'd0, 16'd0, 1'b0));
		send_station(make_station(16'd1, 16'd100, 16'd0, 16'd0, 1'b0));
		send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
	endtask

	task automatic test_exit_choice();
		set_exit_costs(16'hFFFF, 16'h0000);
		send_crossing_pair();
		set_exit_costs(16'h0000, 16'hFFFF);
		send_crossing_pair();
		set_exit_costs(16'hFFFF, 16'hFFFF);
		send_crossing_pair();
	endtask

	// full store, then one and then four stations dropped past capacity
	task automatic test_capacity();
		set_exit_costs(pick_time(), pick_time());
		run_problem(MAX_HELD);
		run_problem(MAX_HELD + 1);
		run_problem(MAX_HELD + 4);
	endtask

	task automatic test_random_problems();
		while (stations_sent < STATION_TARGET) begin
			if ($urandom_range(0, 7) == 0)
				set_exit_costs(pick_time(), pick_time());
			run_problem(pick_length());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_single_station();
		test_ties_and_switches();
		test_exit_choice();
		test_capacity();
		test_random_problems();
		drain_block();
		if (mismatches == 0 && path_due.size() == 0) begin
			$display("[two_line_assembly_schedule] OK");
		end else begin
			$display("[two_line_assembly_schedule] ERROR");
		end
		$finish;
	end

endmodule
